@@ rtl/cos_pkg.sv @@
// ----------------------------------------------------------------------------
// cos_pkg: shared types and constants
// Widths, types and the config reset value for circle separation.
// ----------------------------------------------------------------------------
package cos_pkg;
  localparam int MaxCircles = 32;
  localparam int IdxW       = $clog2(MaxCircles);
  localparam int CntW       = IdxW + 1;
  localparam logic [15:0] EpsReset = 16'd66;

  // one entry of the circle memory
  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic [15:0]        r;
  } circle_t;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [15:0]        radius;
    logic               batch_end;
  } in_req_t;

  typedef struct packed {
    logic [5:0]         circle_index;
    logic signed [23:0] new_x;
    logic signed [23:0] new_y;
    logic               final_result;
  } out_req_t;

  // saturate a wide signed value to 24 bits
  function automatic logic signed [23:0] sat24(input logic signed [49:0] v);
    if (v > 50'sd8388607) return 24'sh7fffff;
    if (v < -50'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction
endpackage

@@ rtl/cos_if.sv @@
// ----------------------------------------------------------------------------
// cos_if: valid/ready channels
// Request channels for circles, results and the epsilon register.
// ----------------------------------------------------------------------------
interface cos_in_if;
  logic valid;
  logic ready;
  cos_pkg::in_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cos_out_if;
  logic valid;
  logic ready;
  cos_pkg::out_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cos_cfg_if;
  logic valid;
  logic ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/cos_divsqrt.sv @@
// ----------------------------------------------------------------------------
// cos_divsqrt: iterative square root and divider
// Floor square root of a 50-bit value, then two truncating divides, one bit
// per cycle each.
// ----------------------------------------------------------------------------
module cos_divsqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [49:0]        d2_i,
  input  logic signed [17:0] rsum_i,
  input  logic signed [24:0] dx_i,
  input  logic signed [24:0] dy_i,
  output logic               done_o,
  output logic signed [24:0] vx_o,
  output logic signed [24:0] vy_o
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_SQRT = 4'b0010, S_PREP = 4'b0100, S_DIV = 4'b1000
  } st_e;

  st_e         st_q, st_d;
  logic [49:0] rem_q, rem_d;
  logic [49:0] bit_q, bit_d;
  logic [49:0] root_q, root_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        sel_q, sel_d;
  logic        neg_q, neg_d;
  logic [43:0] num_q, num_d;
  logic [43:0] quo_q, quo_d;
  logic [44:0] drem_q, drem_d;
  logic [25:0] den_q, den_d;
  logic signed [24:0] dxs_q, dys_q, rsum_q, vx_q, vx_d, vy_q, vy_d;
  logic signed [42:0] prod;
  logic signed [24:0] gap;
  logic [44:0] trial;
  logic [49:0] sum_rb;

  assign gap = $signed(root_q[24:0]) - rsum_q;
  assign prod = gap * (sel_q ? dys_q : dxs_q);
  assign trial = {drem_q[43:0], num_q[43]};
  assign sum_rb = root_q + bit_q;

  // sequencer: sqrt, then divide x then y
  always_comb begin
    st_d = st_q; rem_d = rem_q; bit_d = bit_q; root_d = root_q; cnt_d = cnt_q;
    sel_d = sel_q; neg_d = neg_q; num_d = num_q; quo_d = quo_q;
    drem_d = drem_q; den_d = den_q; vx_d = vx_q; vy_d = vy_q;
    done_o = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (start_i) begin
          rem_d = d2_i; bit_d = 50'd1 << 48; root_d = '0; st_d = S_SQRT;
          sel_d = 1'b0;
        end
      end
      S_SQRT: begin
        if (bit_q == '0) st_d = S_PREP;
        else begin
          if (rem_q >= sum_rb) begin
            rem_d = rem_q - sum_rb; root_d = (root_q >> 1) + bit_q;
          end else root_d = root_q >> 1;
          bit_d = bit_q >> 2;
        end
      end
      S_PREP: begin
        neg_d = prod[42];
        num_d = prod[42] ? 44'(-prod) : 44'(prod);
        den_d = {root_q[24:0], 1'b0};
        drem_d = '0; quo_d = '0; cnt_d = 6'd44; st_d = S_DIV;
      end
      S_DIV: begin
        if (cnt_q == '0) begin
          if (!sel_q) begin
            vx_d = neg_q ? -25'(quo_q) : 25'(quo_q);
            sel_d = 1'b1; st_d = S_PREP;
          end else begin
            vy_d = neg_q ? -25'(quo_q) : 25'(quo_q);
            done_o = 1'b1; st_d = S_IDLE;
          end
        end else begin
          if (trial >= 45'(den_q)) begin
            drem_d = trial - 45'(den_q); quo_d = {quo_q[42:0], 1'b1};
          end else begin
            drem_d = trial; quo_d = {quo_q[42:0], 1'b0};
          end
          num_d = num_q << 1; cnt_d = cnt_q - 6'd1;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  assign vx_o = vx_q;
  assign vy_o = vy_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= S_IDLE;
    else st_q <= st_d;
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; bit_q <= bit_d; root_q <= root_d; cnt_q <= cnt_d;
    sel_q <= sel_d; neg_q <= neg_d; num_q <= num_d; quo_q <= quo_d;
    drem_q <= drem_d; den_q <= den_d; vx_q <= vx_d; vy_q <= vy_d;
    if (start_i && st_q == S_IDLE) begin
      dxs_q <= dx_i; dys_q <= dy_i; rsum_q <= 25'(rsum_i);
    end
  end
endmodule

@@ rtl/circle_overlap_separation_core.sv @@
// ----------------------------------------------------------------------------
// circle_overlap_separation_core: overlap separation of a batch of circles
// Loads circles into one memory, resolves every ordered pair, emits positions.
// ----------------------------------------------------------------------------
// Loading accepts one circle request per cycle. After the batch end request each
// ordered pair is read, squared and tested, then on a collision goes through the
// shared square root and divide unit and the write-back states S_WRI and S_WRJ;
// results then leave one at a time through the S_EMIT and S_EWAIT states.
// Reset clears the sequencer, the circle count and sets epsilon to 66;
// memory contents stay undefined.
module circle_overlap_separation_core (
  input logic clk_i,
  input logic rst_ni,
  cos_in_if.sink    in_i,
  cos_out_if.source out_o,
  cos_cfg_if.sink   cfg_i
);
  typedef enum logic [10:0] {
    S_LOAD = 11'd1, S_RDI = 11'd2, S_RDJ = 11'd4, S_LATI = 11'd8,
    S_SQR = 11'd16, S_TEST = 11'd32, S_CALC = 11'd64, S_WRI = 11'd128,
    S_WRJ = 11'd256, S_EMIT = 11'd512, S_EWAIT = 11'd1024
  } st_e;

  st_e st_q, st_d;
  cos_pkg::circle_t mem_q [cos_pkg::MaxCircles];
  cos_pkg::circle_t rd_q, ci_q;
  logic [cos_pkg::IdxW-1:0] raddr;
  logic we;
  logic [cos_pkg::IdxW-1:0] waddr;
  cos_pkg::circle_t wdata;
  logic [cos_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [cos_pkg::CntW-1:0] i_q, i_d, j_q, j_d;
  logic [15:0] eps_q;
  logic signed [24:0] dx_q, dy_q, vx, vy;
  logic signed [49:0] dxx, dyy;
  logic [49:0] d2_q;
  logic [17:0] rsum_q;
  logic [36:0] min2;
  logic        start, done;
  logic        ovalid_q;
  cos_pkg::out_req_t odata_q;
  logic [cos_pkg::CntW-1:0] eidx_q;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready = (st_q == S_LOAD);
  assign min2 = rsum_q * rsum_q;
  assign dxx = dx_q * dx_q;
  assign dyy = dy_q * dy_q;

  cos_divsqrt u_divsqrt (
    .clk_i, .rst_ni, .start_i(start), .d2_i(d2_q), .rsum_i($signed(rsum_q)),
    .dx_i(dx_q), .dy_i(dy_q), .done_o(done), .vx_o(vx), .vy_o(vy)
  );

  // control sequencer
  always_comb begin
    st_d = st_q; cnt_d = cnt_q; i_d = i_q; j_d = j_q;
    raddr = i_q[cos_pkg::IdxW-1:0]; we = 1'b0;
    waddr = cnt_q[cos_pkg::IdxW-1:0];
    wdata = '{x: in_i.data.pos_x, y: in_i.data.pos_y, r: in_i.data.radius};
    start = 1'b0;
    case (st_q)
      S_LOAD: begin
        if (in_i.valid) begin
          if (cnt_q < cos_pkg::CntW'(cos_pkg::MaxCircles)) begin
            we = 1'b1; cnt_d = cnt_q + 1'b1;
          end
          if (in_i.data.batch_end) begin
            i_d = '0; j_d = '0; st_d = S_RDI;
          end
        end
      end
      S_RDI: begin
        if (i_q >= cnt_q) begin
          i_d = '0; st_d = S_EMIT;
        end else if (j_q >= cnt_q) begin
          i_d = i_q + 1'b1; j_d = '0;
        end else if (i_q == j_q) j_d = j_q + 1'b1;
        else st_d = S_RDJ;
      end
      S_RDJ: begin raddr = j_q[cos_pkg::IdxW-1:0]; st_d = S_LATI; end
      // keep circle j on the read port until the write-back
      S_LATI: begin raddr = j_q[cos_pkg::IdxW-1:0]; st_d = S_SQR; end
      S_SQR: begin raddr = j_q[cos_pkg::IdxW-1:0]; st_d = S_TEST; end
      S_TEST: begin
        raddr = j_q[cos_pkg::IdxW-1:0];
        if (d2_q > 50'(eps_q) && 50'(min2) + 50'(eps_q) >= d2_q) begin
          start = 1'b1; st_d = S_CALC;
        end else begin j_d = j_q + 1'b1; st_d = S_RDI; end
      end
      S_CALC: begin
        raddr = j_q[cos_pkg::IdxW-1:0];
        if (done) st_d = S_WRI;
      end
      S_WRI: begin
        raddr = j_q[cos_pkg::IdxW-1:0];
        we = 1'b1; waddr = i_q[cos_pkg::IdxW-1:0];
        wdata = '{x: cos_pkg::sat24(50'(ci_q.x) - 50'(vx)),
                  y: cos_pkg::sat24(50'(ci_q.y) - 50'(vy)), r: ci_q.r};
        st_d = S_WRJ;
      end
      S_WRJ: begin
        we = 1'b1; waddr = j_q[cos_pkg::IdxW-1:0];
        wdata = '{x: cos_pkg::sat24(50'(rd_q.x) + 50'(vx)),
                  y: cos_pkg::sat24(50'(rd_q.y) + 50'(vy)), r: rd_q.r};
        j_d = j_q + 1'b1; st_d = S_RDI;
      end
      S_EMIT: begin
        if (i_q >= cnt_q) begin cnt_d = '0; st_d = S_LOAD; end
        else if (!ovalid_q || out_o.ready) st_d = S_EWAIT;
      end
      S_EWAIT: begin i_d = i_q + 1'b1; st_d = S_EMIT; end
      default: st_d = S_LOAD;
    endcase
  end

  // circle memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rd_q <= mem_q[raddr];
  end

  // pair operands: i is latched, then the difference vs j
  always_ff @(posedge clk_i) begin
    if (st_q == S_RDJ) ci_q <= rd_q;
    if (st_q == S_LATI) begin
      dx_q <= 25'(ci_q.x) - 25'(rd_q.x);
      dy_q <= 25'(ci_q.y) - 25'(rd_q.y);
      rsum_q <= 18'(ci_q.r) + 18'(rd_q.r);
    end
    d2_q <= $unsigned(dxx) + $unsigned(dyy);
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else if (st_q == S_EWAIT) ovalid_q <= 1'b1;
    else if (out_o.ready) ovalid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_EMIT) eidx_q <= i_q;
    if (st_q == S_EWAIT) begin
      odata_q.circle_index <= 6'(eidx_q);
      odata_q.new_x <= rd_q.x;
      odata_q.new_y <= rd_q.y;
      odata_q.final_result <= (eidx_q + 1'b1 == cnt_q);
    end
  end

  assign out_o.valid = ovalid_q;
  assign out_o.data = odata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_LOAD; cnt_q <= '0; i_q <= '0; j_q <= '0;
      eps_q <= cos_pkg::EpsReset;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; i_q <= i_d; j_q <= j_d;
      if (cfg_i.valid) eps_q <= cfg_i.data;
    end
  end

  // checks
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= cos_pkg::CntW'(cos_pkg::MaxCircles)) else $error("count overflow");
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != S_LOAD) |-> !in_i.ready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> out_o.valid) else $error("result dropped");
endmodule

@@ dv/cos_tb_if.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cos_tb_if: testbench channel notes
// The block's request channels come from the RTL interface file; this file
// holds the test-side constants shared by the bench.
// ----------------------------------------------------------------------------
package cos_tb_pkg;
  // idle percentages per phase
  localparam int LoadIdlePct = 25;
  localparam int DrainIdlePct = 46;
endpackage

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: circle overlap separation check
// Loads batches of circles, predicts the separated positions with a
// fixed-point model of the pair resolution and compares every emitted circle.
// ----------------------------------------------------------------------------
module testbench;
  localparam int WatchLimit = 600000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cos_in_if  in_ch();
  cos_out_if out_ch();
  cos_cfg_if cfg_ch();

  circle_overlap_separation_core u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source),
    .cfg_i (cfg_ch.sink)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic signed [23:0] sep_x[cos_pkg::MaxCircles];
  logic signed [23:0] sep_y[cos_pkg::MaxCircles];
  logic [15:0]        sep_r[cos_pkg::MaxCircles];
  int                 held_count;
  logic [15:0]        eps_model;

  cos_pkg::in_req_t  pending_circles[$];
  cos_pkg::out_req_t expected_positions[$];
  int       mismatch_count;
  int       send_idle_pct;
  int       recv_idle_pct;
  int       idle_cycles;
  bit       cfg_busy;
  bit       timed_out;

  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic signed [23:0] clip24(input longint v);
    if (v > 64'sd8388607) return 24'sh7fffff;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  // one ordered pair, positions as already updated
  task automatic separate_pair(input int i, input int j);
    longint dx, dy, rsum, root_dist, gap, vx, vy;
    logic [63:0] d2, min2;
    dx = longint'(sep_x[i]) - longint'(sep_x[j]);
    dy = longint'(sep_y[i]) - longint'(sep_y[j]);
    d2 = 64'(dx * dx) + 64'(dy * dy);
    rsum = longint'(sep_r[i]) + longint'(sep_r[j]);
    min2 = 64'(rsum * rsum);
    if (!(d2 > 64'(eps_model) && min2 + 64'(eps_model) >= d2)) return;
    root_dist = longint'(root_floor(d2));
    if (root_dist <= 0) return;
    gap = root_dist - rsum;
    vx = (gap * dx) / (2 * root_dist);
    vy = (gap * dy) / (2 * root_dist);
    sep_x[i] = clip24(longint'(sep_x[i]) - vx);
    sep_y[i] = clip24(longint'(sep_y[i]) - vy);
    sep_x[j] = clip24(longint'(sep_x[j]) + vx);
    sep_y[j] = clip24(longint'(sep_y[j]) + vy);
  endtask

  // store a circle and resolve the batch on its last circle
  task automatic predict_circle(input cos_pkg::in_req_t c);
    cos_pkg::out_req_t o;
    if (held_count < cos_pkg::MaxCircles) begin
      sep_x[held_count] = c.pos_x;
      sep_y[held_count] = c.pos_y;
      sep_r[held_count] = c.radius;
      held_count++;
    end
    if (!c.batch_end) return;
    for (int i = 0; i < held_count; i++)
      for (int j = 0; j < held_count; j++)
        if (i != j) separate_pair(i, j);
    for (int i = 0; i < held_count; i++) begin
      o.circle_index = 6'(i);
      o.new_x = sep_x[i];
      o.new_y = sep_y[i];
      o.final_result = (i + 1 == held_count);
      expected_positions.insert(expected_positions.size(), o);
    end
    held_count = 0;
  endtask

  // driver: circle requests
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) predict_circle(in_ch.data);
      if (pending_circles.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.data <= pending_circles.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor: result requests and backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      idle_cycles <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_positions.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result %p", out_ch.data);
        end else begin
          cos_pkg::out_req_t e;
          e = expected_positions.pop_front();
          if (e !== out_ch.data) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result mismatch: expected %p actual %p", e, out_ch.data);
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (idle_cycles >= WatchLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_epsilon(input logic [15:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    eps_model = v;
    cfg_ch.valid <= 1'b0;
  endtask

  // wait until every expected result is back, then a settle gap
  task automatic drain_all();
    while (pending_circles.size() > 0 || in_ch.valid ||
           expected_positions.size() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  function automatic cos_pkg::in_req_t make_circle(input bit last);
    cos_pkg::in_req_t c;
    c.pos_x = 24'($urandom_range(6000)) - 24'sd3000;
    c.pos_y = 24'($urandom_range(6000)) - 24'sd3000;
    c.radius = 16'($urandom_range(1200));
    c.batch_end = last;
    return c;
  endfunction

  // a well-formed batch of n circles
  task automatic queue_batch(input int n);
    cos_pkg::in_req_t c;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) == 0) begin
        c.pos_x = 24'($urandom);
        c.pos_y = 24'($urandom);
        c.radius = 16'($urandom);
        c.batch_end = (k == n - 1);
      end else begin
        c = make_circle(k == n - 1);
      end
      pending_circles.insert(pending_circles.size(), c);
    end
  endtask

  task automatic push_c(input int x, input int y, input int r, input bit last);
    cos_pkg::in_req_t c;
    c.pos_x = 24'(x);
    c.pos_y = 24'(y);
    c.radius = 16'(r);
    c.batch_end = last;
    pending_circles.insert(pending_circles.size(), c);
  endtask

  initial begin
    int sent;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    held_count = 0;
    eps_model = cos_pkg::EpsReset;
    mismatch_count = 0;
    timed_out = 1'b0;
    send_idle_pct = cos_tb_pkg::LoadIdlePct;
    recv_idle_pct = cos_tb_pkg::DrainIdlePct;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: single circle, coincident centres, extremes, saturation
    push_c(100, -100, 50, 1'b1);
    push_c(0, 0, 256, 1'b0);
    push_c(0, 0, 256, 1'b1);
    push_c(0, 0, 512, 1'b0);
    push_c(300, 0, 512, 1'b0);
    push_c(0, 300, 65535, 1'b1);
    push_c(8388607, 8388607, 65535, 1'b0);
    push_c(8388000, 8388000, 65535, 1'b1);
    push_c(-8388608, -8388608, 65535, 1'b0);
    push_c(-8388000, -8388608, 65535, 1'b1);
    push_c(0, 0, 0, 1'b0);
    push_c(1, 0, 0, 1'b1);
    drain_all();
    write_epsilon(16'd0);
    push_c(0, 0, 0, 1'b0);
    push_c(1, 1, 1, 1'b1);
    push_c(5, 5, 100, 1'b0);
    push_c(5, 5, 100, 1'b1);
    drain_all();
    write_epsilon(16'hffff);
    push_c(0, 0, 10, 1'b0);
    push_c(100, 0, 10, 1'b0);
    push_c(200, 0, 10, 1'b1);
    drain_all();
    write_epsilon(cos_pkg::EpsReset);

    // store full: 33 circles, the last one dropped
    for (int k = 0; k < 33; k++)
      push_c(k * 400, -k * 300, 300, k == 32);
    drain_all();

    // random batches in three idling phases
    sent = 0;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? cos_tb_pkg::LoadIdlePct :
                      (ph == 1) ? cos_tb_pkg::DrainIdlePct : 0;
      recv_idle_pct = (ph == 0) ? cos_tb_pkg::DrainIdlePct :
                      (ph == 1) ? cos_tb_pkg::LoadIdlePct : 0;
      while (sent < 105 * (ph + 1)) begin
        int n;
        n = ($urandom_range(19) == 0) ? cos_pkg::MaxCircles : $urandom_range(8, 1);
        queue_batch(n);
        sent += n;
        if ($urandom_range(4) == 0) begin
          drain_all();
          write_epsilon(16'($urandom));
        end
      end
      drain_all();
    end

    if (mismatch_count == 0 && expected_positions.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
